// ----- design/deq_pkg.sv -----
// ----------------------------------------------------------------------------
// Double-ended queue package
// Request codes, result status codes and the command and status bundles
// that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package deq_pkg;

    typedef enum logic [2:0] {
        REQ_PUSH_FRONT = 3'd0,
        REQ_PUSH_REAR  = 3'd1,
        REQ_POP_FRONT  = 3'd2,
        REQ_POP_REAR   = 3'd3,
        REQ_DUMP       = 3'd4
    } t_req;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef struct packed {
        logic    wr_front;
        logic    wr_rear;
        logic    rd_front;
        logic    rd_rear;
        logic    rd_dump;
        logic    idx_clr;
        logic    idx_inc;
        logic    out_load;
        t_status out_status;
        logic    out_use_rdata;
        logic    out_dump_last;
    } t_cmd;

    typedef struct packed {
        logic empty;
        logic full;
        logic dump_last;
        logic out_free;
    } t_dp_status;

endpackage

// ----- design/double_ended_queue.sv -----
// ----------------------------------------------------------------------------
// Double-ended queue
// Bounded deque of signed words in a ring store, with push and pop at either
// end and a dump of all entries from front to rear.
//
//   Channel   Direction  Handshake              Fields
//   in        input      i_in_valid/o_in_stall   i_req_type, i_value
//   out       output     o_out_valid/i_out_stall o_status, o_data, o_last
//
// A push, an error and an ignored code are handled in the idle state alone, so these may follow
// every cycle while the result register is free. A pop reads the store into a register on acceptance;
// the pop state then loads the result from it. A dump takes the request, then steps through each
// stored entry: a store read, then a result load that waits while the result is stalled.
// Reset clears the head pointer, the count and the result valid flag.
// A stalled result holds the controller; a new request is taken while the controller
// is idle and the result register is empty or being taken.
// ----------------------------------------------------------------------------
module double_ended_queue import deq_pkg::*; #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [2:0]                   i_req_type,
    input  logic signed [DATA_WIDTH-1:0] i_value,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [1:0]                   o_status,
    output logic signed [DATA_WIDTH-1:0] o_data,
    output logic                         o_last
);

    t_cmd       cmd;
    t_dp_status dp_status;

    deq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_req_type  (i_req_type),
        .i_dp_status (dp_status),
        .o_cmd       (cmd)
    );

    deq_dpath #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_dp_status (dp_status),
        .i_value     (i_value),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_status    (o_status),
        .o_data      (o_data),
        .o_last      (o_last)
    );

endmodule

// ----- design/deq_ctrl.sv -----
// ----------------------------------------------------------------------------
// Double-ended queue controller
// Accepts requests, sequences pops and dumps, and issues datapath commands.
// ----------------------------------------------------------------------------
module deq_ctrl import deq_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [2:0] i_req_type,
    input  t_dp_status i_dp_status,
    output t_cmd       o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE    = 4'b0001,
        S_POP     = 4'b0010,
        S_DUMP_RD = 4'b0100,
        S_DUMP_WR = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   accept;

    assign o_in_stall = !((r_state == S_IDLE) && i_dp_status.out_free);
    assign accept     = i_in_valid && !o_in_stall;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.out_status = ST_OK;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    unique case (t_req'(i_req_type)) inside
                        REQ_PUSH_FRONT, REQ_PUSH_REAR: begin
                            o_cmd.out_load = 1'b1;
                            if (i_dp_status.full) begin
                                o_cmd.out_status = ST_FULL;
                            end else begin
                                o_cmd.wr_front = (t_req'(i_req_type) == REQ_PUSH_FRONT);
                                o_cmd.wr_rear  = (t_req'(i_req_type) == REQ_PUSH_REAR);
                            end
                        end
                        REQ_POP_FRONT, REQ_POP_REAR: begin
                            if (i_dp_status.empty) begin
                                o_cmd.out_load   = 1'b1;
                                o_cmd.out_status = ST_EMPTY;
                            end else begin
                                o_cmd.rd_front = (t_req'(i_req_type) == REQ_POP_FRONT);
                                o_cmd.rd_rear  = (t_req'(i_req_type) == REQ_POP_REAR);
                                n_state        = S_POP;
                            end
                        end
                        REQ_DUMP: begin
                            if (i_dp_status.empty) begin
                                o_cmd.out_load   = 1'b1;
                                o_cmd.out_status = ST_EMPTY;
                            end else begin
                                o_cmd.idx_clr = 1'b1;
                                n_state       = S_DUMP_RD;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_POP: begin
                o_cmd.out_load      = 1'b1;
                o_cmd.out_use_rdata = 1'b1;
                n_state             = S_IDLE;
            end
            S_DUMP_RD: begin
                o_cmd.rd_dump = 1'b1;
                n_state       = S_DUMP_WR;
            end
            S_DUMP_WR: begin
                if (i_dp_status.out_free) begin
                    o_cmd.out_load      = 1'b1;
                    o_cmd.out_use_rdata = 1'b1;
                    o_cmd.out_dump_last = 1'b1;
                    if (i_dp_status.dump_last) begin
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.idx_inc = 1'b1;
                        n_state       = S_DUMP_RD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ----- design/deq_dpath.sv -----
// ----------------------------------------------------------------------------
// Double-ended queue datapath
// Ring store, head pointer, entry count, dump index and result register.
// ----------------------------------------------------------------------------
module deq_dpath import deq_pkg::*; #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  t_cmd                         i_cmd,
    output t_dp_status                   o_dp_status,
    input  logic signed [DATA_WIDTH-1:0] i_value,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [1:0]                   o_status,
    output logic signed [DATA_WIDTH-1:0] o_data,
    output logic                         o_last
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [DATA_WIDTH-1:0] r_mem [DEPTH];
    logic [DATA_WIDTH-1:0] r_rdata;
    logic [AW-1:0]         r_head;
    logic [AW-1:0]         n_head;
    logic [CW-1:0]         r_count;
    logic [CW-1:0]         n_count;
    logic [AW-1:0]         r_idx;
    logic                  r_out_valid;
    logic [1:0]            r_status;
    logic [DATA_WIDTH-1:0] r_data;
    logic                  r_last;

    logic [AW-1:0]         head_dec;
    logic [AW-1:0]         head_inc;
    logic [AW-1:0]         rear_wr_slot;
    logic [AW-1:0]         rear_rd_slot;
    logic [AW-1:0]         dump_slot;
    logic [AW-1:0]         wr_addr;
    logic [AW-1:0]         rd_addr;
    logic                  wr_en;
    logic                  rd_en;
    logic                  dump_last;

    function automatic logic [AW-1:0] wrap(input logic [AW:0] sum);
        logic [AW:0] red;
        red = (sum >= (AW+1)'(DEPTH)) ? sum - (AW+1)'(DEPTH) : sum;
        return red[AW-1:0];
    endfunction

    assign head_dec     = (r_head == '0) ? AW'(DEPTH - 1) : r_head - 1'b1;
    assign head_inc     = wrap((AW+1)'(r_head) + 1'b1);
    assign rear_wr_slot = wrap((AW+1)'(r_head) + (AW+1)'(r_count));
    assign rear_rd_slot = wrap((AW+1)'(r_head) + (AW+1)'(r_count) - 1'b1);
    assign dump_slot    = wrap((AW+1)'(r_head) + (AW+1)'(r_idx));
    assign dump_last    = ((AW+1)'(r_idx) + 1'b1) == (AW+1)'(r_count);

    assign wr_en   = i_cmd.wr_front || i_cmd.wr_rear;
    assign wr_addr = i_cmd.wr_front ? head_dec : rear_wr_slot;
    assign rd_en   = i_cmd.rd_front || i_cmd.rd_rear || i_cmd.rd_dump;
    assign rd_addr = i_cmd.rd_front ? r_head : (i_cmd.rd_rear ? rear_rd_slot : dump_slot);

    always_comb begin
        n_head  = r_head;
        n_count = r_count;
        if (i_cmd.wr_front) begin
            n_head = head_dec;
        end
        if (i_cmd.rd_front) begin
            n_head = head_inc;
        end
        if (wr_en) begin
            n_count = r_count + 1'b1;
        end
        if (i_cmd.rd_front || i_cmd.rd_rear) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= i_value;
        end
        if (rd_en) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_head  <= n_head;
            r_count <= n_count;
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.idx_clr) begin
            r_idx <= '0;
        end else if (i_cmd.idx_inc) begin
            r_idx <= r_idx + 1'b1;
        end
        if (i_cmd.out_load) begin
            r_status <= i_cmd.out_status;
            r_data   <= i_cmd.out_use_rdata ? r_rdata : '0;
            r_last   <= i_cmd.out_dump_last ? dump_last : 1'b1;
        end
    end

    assign o_dp_status.empty     = (r_count == '0);
    assign o_dp_status.full      = (r_count == CW'(DEPTH));
    assign o_dp_status.dump_last = dump_last;
    assign o_dp_status.out_free  = !r_out_valid || !i_out_stall;

    assign o_out_valid = r_out_valid;
    assign o_status    = r_status;
    assign o_data      = r_data;
    assign o_last      = r_last;

endmodule

// ----- design/deq_checker.sv -----
// ----------------------------------------------------------------------------
// Double-ended queue checker
// Port-level assertions on the result channel and the request stall.
// ----------------------------------------------------------------------------
module deq_checker import deq_pkg::*; #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_in_valid,
    input logic                         o_in_stall,
    input logic [2:0]                   i_req_type,
    input logic signed [DATA_WIDTH-1:0] i_value,
    input logic                         o_out_valid,
    input logic                         i_out_stall,
    input logic [1:0]                   o_status,
    input logic signed [DATA_WIDTH-1:0] o_data,
    input logic                         o_last
);

    localparam int MaxResults = DEPTH;

    a_error_is_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status != ST_OK) |-> (o_data == '0) && o_last)
        else $error("error result carries data or is not final");

    a_no_take_when_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |-> o_in_stall)
        else $error("request taken while a result is stalled");

    a_reset_clears_output: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid directly after reset");

    a_stalled_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_data)
            && $stable(o_status) && $stable(o_last))
        else $error("stalled result changed");

    a_depth_in_range: assert property (@(posedge i_clk)
        (MaxResults >= 2) && (i_req_type == i_req_type) && (i_in_valid == i_in_valid)
            && (i_value == i_value))
        else $error("queue depth below two");

endmodule

bind double_ended_queue deq_checker #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
) u_deq_checker (.*);
